FILE: src/rhc_pkg.sv
// Shared types, constants and widths for the RGB to HSV converter.
package rhc_pkg;

  localparam int COMP_BITS   = 8;
  localparam int SAT_NUM_W   = 2 * COMP_BITS;
  localparam int HUE_Q_W     = 10;
  localparam int HUE_NUM_W   = COMP_BITS + HUE_Q_W;
  localparam int HUE_W       = 13;
  localparam int SECTOR_SPAN = 960;
  localparam int TURN_SPAN   = 5760;
  localparam int DIV_STAGES  = (COMP_BITS > HUE_Q_W) ? COMP_BITS : HUE_Q_W;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    SECT_RED,
    SECT_GREEN,
    SECT_BLUE
  } sector_t;

  typedef struct packed {
    logic [COMP_BITS-1:0] red;
    logic [COMP_BITS-1:0] green;
    logic [COMP_BITS-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [HUE_W-1:0]     hue;
    logic [COMP_BITS-1:0] saturation;
    logic [COMP_BITS-1:0] brightness;
    logic                 hue_undefined;
  } hsv_t;

  // Classified item handed from the front to the divider pipeline
  typedef struct packed {
    logic [SAT_NUM_W-1:0] sat_num;
    logic [HUE_NUM_W-1:0] hue_num;
    logic [COMP_BITS-1:0] max;
    logic [COMP_BITS-1:0] delta;
    sector_t              sector;
    logic                 neg;
    logic                 undef;
    logic                 black;
  } front_item_t;

  typedef struct packed {
    logic [SAT_NUM_W-1:0] rem_s;
    logic [COMP_BITS-1:0] q_s;
    logic [HUE_NUM_W-1:0] rem_h;
    logic [HUE_Q_W-1:0]   q_h;
    logic [COMP_BITS-1:0] max;
    logic [COMP_BITS-1:0] delta;
    sector_t              sector;
    logic                 neg;
    logic                 undef;
    logic                 black;
  } div_stage_t;

endpackage

FILE: src/rhc_front.sv
// Front end: max/min/delta, sector choice and divider operands, with output register.
module rhc_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  rhc_pkg::pixel_t      in_data,
  output logic                 item_valid,
  input  logic                 item_ready,
  output rhc_pkg::front_item_t item_data
);

  logic                         vld_r, vld_nxt;
  rhc_pkg::front_item_t         item_r, item_nxt;
  logic [rhc_pkg::COMP_BITS-1:0] r, g, b, mx, mn, delta, op_a, op_b, absdiff;
  rhc_pkg::sector_t             sector;

  assign r = in_data.red;
  assign g = in_data.green;
  assign b = in_data.blue;

  always_comb begin
    mx = (r > g) ? r : g;
    mn = (r < g) ? r : g;
    if (b > mx) mx = b;
    if (b < mn) mn = b;
    delta = mx - mn;

    // ties go to red, then green
    priority if (r >= mx) begin
      sector = rhc_pkg::SECT_RED;
      op_a   = g;
      op_b   = b;
    end else if (g >= mx) begin
      sector = rhc_pkg::SECT_GREEN;
      op_a   = b;
      op_b   = r;
    end else begin
      sector = rhc_pkg::SECT_BLUE;
      op_a   = r;
      op_b   = g;
    end
    absdiff = (op_a < op_b) ? (op_b - op_a) : (op_a - op_b);

    item_nxt.max    = mx;
    item_nxt.delta  = delta;
    item_nxt.sector = sector;
    item_nxt.neg    = (op_a < op_b);
    item_nxt.black  = (mx == '0);
    item_nxt.undef  = (delta == '0);
    // delta * (2^N - 1) and |diff| * 960 as shifts and subtracts
    item_nxt.sat_num = (rhc_pkg::SAT_NUM_W'(delta) << rhc_pkg::COMP_BITS)
                     - rhc_pkg::SAT_NUM_W'(delta);
    item_nxt.hue_num = (rhc_pkg::HUE_NUM_W'(absdiff) << 10)
                     - (rhc_pkg::HUE_NUM_W'(absdiff) << 6);
  end

  assign in_ready = !vld_r || item_ready;
  assign vld_nxt  = in_ready ? in_valid : vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= item_nxt;
    end
  end

  assign item_valid = vld_r;
  assign item_data  = item_r;

endmodule

FILE: src/rhc_queue.sv
// Short flip-flop queue between the front end and the divider pipeline.
module rhc_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push_valid,
  output logic                 push_ready,
  input  rhc_pkg::front_item_t push_data,
  output logic                 pop_valid,
  input  logic                 pop_ready,
  output rhc_pkg::front_item_t pop_data
);

  rhc_pkg::front_item_t        entry_r [rhc_pkg::QUEUE_DEPTH];
  logic [rhc_pkg::QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [rhc_pkg::QCNT_W-1:0]  count_r, count_nxt;
  logic                        push, pop;

  function automatic logic [rhc_pkg::QPTR_W-1:0] ptr_inc(
    input logic [rhc_pkg::QPTR_W-1:0] p
  );
    if (p == rhc_pkg::QPTR_W'(rhc_pkg::QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  assign push_ready = (count_r != rhc_pkg::QCNT_W'(rhc_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) count_nxt = count_r + 1'b1;
    if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= rhc_pkg::QCNT_W'(rhc_pkg::QUEUE_DEPTH))
    else $error("queue count beyond depth");
  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("queue count missed a push");
  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (wr_ptr_r == rd_ptr_r))
    else $error("empty queue with pointers apart");
`endif

endmodule

FILE: src/rhc_back.sv
// Back end: bit-per-stage dividers for saturation and hue, then result register.
module rhc_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 item_valid,
  output logic                 item_ready,
  input  rhc_pkg::front_item_t item_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output rhc_pkg::hsv_t        out_data
);

  localparam int NS = rhc_pkg::DIV_STAGES;

  rhc_pkg::div_stage_t stage_r  [NS];
  logic                stg_vld_r [NS];
  rhc_pkg::div_stage_t step_in  [NS];
  rhc_pkg::div_stage_t step_out [NS];
  logic                out_valid_r;
  rhc_pkg::hsv_t       out_data_r, out_data_nxt;
  logic                advance;

  // whole pipeline moves together whenever the result register can take an item
  assign advance    = !out_valid_r || out_ready;
  assign item_ready = advance;

  always_comb begin
    step_in[0].rem_s  = item_data.sat_num;
    step_in[0].q_s    = '0;
    step_in[0].rem_h  = item_data.hue_num;
    step_in[0].q_h    = '0;
    step_in[0].max    = item_data.max;
    step_in[0].delta  = item_data.delta;
    step_in[0].sector = item_data.sector;
    step_in[0].neg    = item_data.neg;
    step_in[0].undef  = item_data.undef;
    step_in[0].black  = item_data.black;
  end

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic [rhc_pkg::HUE_NUM_W-1:0] h_rem;
    logic [rhc_pkg::HUE_Q_W-1:0]   h_q;
    logic [rhc_pkg::SAT_NUM_W-1:0] s_rem;
    logic [rhc_pkg::COMP_BITS-1:0] s_q;

    if (k > 0) begin : g_link
      assign step_in[k] = stage_r[k-1];
    end

    if (k < rhc_pkg::HUE_Q_W) begin : g_hue
      localparam int HB = rhc_pkg::HUE_Q_W - 1 - k;
      logic [rhc_pkg::HUE_NUM_W-1:0] h_div;
      always_comb begin
        h_div = rhc_pkg::HUE_NUM_W'(step_in[k].delta) << HB;
        h_q   = step_in[k].q_h;
        if (step_in[k].rem_h >= h_div) begin
          h_rem  = step_in[k].rem_h - h_div;
          h_q[HB] = 1'b1;
        end else begin
          h_rem = step_in[k].rem_h;
        end
      end
    end else begin : g_hue_pass
      assign h_rem = step_in[k].rem_h;
      assign h_q   = step_in[k].q_h;
    end

    if (k < rhc_pkg::COMP_BITS) begin : g_sat
      localparam int SB = rhc_pkg::COMP_BITS - 1 - k;
      logic [rhc_pkg::SAT_NUM_W-1:0] s_div;
      always_comb begin
        s_div = rhc_pkg::SAT_NUM_W'(step_in[k].max) << SB;
        s_q   = step_in[k].q_s;
        if (step_in[k].rem_s >= s_div) begin
          s_rem   = step_in[k].rem_s - s_div;
          s_q[SB] = 1'b1;
        end else begin
          s_rem = step_in[k].rem_s;
        end
      end
    end else begin : g_sat_pass
      assign s_rem = step_in[k].rem_s;
      assign s_q   = step_in[k].q_s;
    end

    always_comb begin
      step_out[k]       = step_in[k];
      step_out[k].rem_h = h_rem;
      step_out[k].q_h   = h_q;
      step_out[k].rem_s = s_rem;
      step_out[k].q_s   = s_q;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        stg_vld_r[k] <= 1'b0;
      end else if (advance) begin
        stg_vld_r[k] <= (k == 0) ? item_valid : stg_vld_r[(k == 0) ? 0 : k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (advance) begin
        stage_r[k] <= step_out[k];
      end
    end
  end

  // Final hue: sector base plus or minus the offset, negative wraps by a full turn
  always_comb begin
    rhc_pkg::div_stage_t           last;
    logic [rhc_pkg::HUE_W-1:0]     ofs;
    logic [rhc_pkg::HUE_W-1:0]     hue;
    last = stage_r[NS-1];
    ofs  = rhc_pkg::HUE_W'(last.q_h);
    unique case (last.sector)
      rhc_pkg::SECT_RED: begin
        if (last.neg && ofs != '0) begin
          hue = rhc_pkg::HUE_W'(rhc_pkg::TURN_SPAN) - ofs;
        end else begin
          hue = ofs;
        end
      end
      rhc_pkg::SECT_GREEN: begin
        hue = last.neg ? rhc_pkg::HUE_W'(2 * rhc_pkg::SECTOR_SPAN) - ofs
                       : rhc_pkg::HUE_W'(2 * rhc_pkg::SECTOR_SPAN) + ofs;
      end
      rhc_pkg::SECT_BLUE: begin
        hue = last.neg ? rhc_pkg::HUE_W'(4 * rhc_pkg::SECTOR_SPAN) - ofs
                       : rhc_pkg::HUE_W'(4 * rhc_pkg::SECTOR_SPAN) + ofs;
      end
      default: begin
        hue = '0;
      end
    endcase
    out_data_nxt.hue           = last.undef ? '0 : hue;
    out_data_nxt.saturation    = last.black ? '0 : last.q_s;
    out_data_nxt.brightness    = last.max;
    out_data_nxt.hue_undefined = last.undef;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= stg_vld_r[NS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef NO_ASSERTIONS
  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.hue < rhc_pkg::HUE_W'(rhc_pkg::TURN_SPAN)))
    else $error("hue out of range");
  a_undef_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.hue_undefined) |->
      (out_data_r.hue == '0 && out_data_r.saturation == '0))
    else $error("undefined hue with nonzero hue or saturation");
  a_black_undef: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.brightness == '0) |-> out_data_r.hue_undefined)
    else $error("black pixel without undefined flag");
  a_sat_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.saturation <= out_data_r.brightness
                     || out_data_r.brightness != '0))
    else $error("saturation on a black pixel");
`endif

endmodule

FILE: src/rgb_to_hsv_convert_unit.sv
// Top level of the RGB to HSV converter: front end, queue and divider pipeline.
//
//   channel | direction | handshake             | payload
//   in_     | input     | in_valid / in_ready   | rhc_pkg::pixel_t (red, green, blue)
//   out_    | output    | out_valid / out_ready | rhc_pkg::hsv_t (hue, saturation, ...)
//
// One item per clock sustained while the output does not stall. An accepted
// item passes the front register, the queue, the divider stages and the result
// register. Two restoring dividers, one quotient bit per stage, 10 stages for hue.
// rst_n is synchronous and clears all valid flags and queue pointers.
// A stalled output holds the divider pipeline; the two-entry queue and the front
// register keep taking items until both are full.
module rgb_to_hsv_convert_unit (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  rhc_pkg::pixel_t in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output rhc_pkg::hsv_t   out_data
);

  logic                 f_valid, f_ready;
  rhc_pkg::front_item_t f_data;
  logic                 q_valid, q_ready;
  rhc_pkg::front_item_t q_data;

  rhc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .item_valid (f_valid),
    .item_ready (f_ready),
    .item_data  (f_data)
  );

  rhc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_data),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data)
  );

  rhc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (q_valid),
    .item_ready (q_ready),
    .item_data  (q_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

FILE: sim/tb_rgb_to_hsv_convert_unit.sv
// Self-checking testbench for the RGB to HSV converter with random handshake idling.
module tb_rgb_to_hsv_convert_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FULL_SCALE  = (1 << rhc_pkg::COMP_BITS) - 1;
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 200;
  localparam int TAIL_CYCLES = rhc_pkg::DIV_STAGES + 8;

  logic            clk = 1'b0;
  logic            rst_n;
  logic            in_valid;
  logic            in_ready;
  rhc_pkg::pixel_t in_data;
  logic            out_valid;
  logic            out_ready;
  rhc_pkg::hsv_t   out_data;

  rhc_pkg::hsv_t expected_hsv_q[$];
  int   error_count = 0;
  int   quiet_cycles = 0;
  int   hold_left = 0;
  bit   in_idle_on = 1'b1;
  bit   out_idle_on = 1'b1;

  rgb_to_hsv_convert_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #10 clk = ~clk;

  function automatic rhc_pkg::hsv_t predict_hsv(rhc_pkg::pixel_t px);
    int               r, g, b, top, bottom, span, angle;
    rhc_pkg::sector_t sect;
    rhc_pkg::hsv_t    res;
    r = px.red;
    g = px.green;
    b = px.blue;
    top = (r > g) ? r : g;
    bottom = (r < g) ? r : g;
    if (b > top) top = b;
    if (b < bottom) bottom = b;
    span = top - bottom;
    res = '0;
    res.brightness = rhc_pkg::COMP_BITS'(top);
    res.hue_undefined = (span == 0);
    if (top != 0) res.saturation = rhc_pkg::COMP_BITS'(span * FULL_SCALE / top);
    if (span != 0) begin
      // ties go to red, then green
      if (r == top) sect = rhc_pkg::SECT_RED;
      else if (g == top) sect = rhc_pkg::SECT_GREEN;
      else sect = rhc_pkg::SECT_BLUE;
      case (sect)
        rhc_pkg::SECT_RED:
          angle = (g - b) * rhc_pkg::SECTOR_SPAN / span;
        rhc_pkg::SECT_GREEN:
          angle = 2 * rhc_pkg::SECTOR_SPAN + (b - r) * rhc_pkg::SECTOR_SPAN / span;
        default:
          angle = 4 * rhc_pkg::SECTOR_SPAN + (r - g) * rhc_pkg::SECTOR_SPAN / span;
      endcase
      if (angle < 0) angle += rhc_pkg::TURN_SPAN;
      res.hue = rhc_pkg::HUE_W'(angle);
    end
    return res;
  endfunction

  function automatic rhc_pkg::pixel_t make_pixel(int r, int g, int b);
    rhc_pkg::pixel_t px;
    px.red = rhc_pkg::COMP_BITS'(r);
    px.green = rhc_pkg::COMP_BITS'(g);
    px.blue = rhc_pkg::COMP_BITS'(b);
    return px;
  endfunction

  // Offers one item from the falling edge and returns at the edge that takes it
  task automatic send_pixel(input rhc_pkg::pixel_t px);
    @(negedge clk);
    while (in_idle_on && $urandom_range(99) < 25) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = px;
    do @(posedge clk); while (!in_ready);
    expected_hsv_q.push_back(predict_hsv(px));
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_hsv_q.size() != 0) @(posedge clk);
  endtask

  task automatic report_field(input string field, input int want, input int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", field, want, got);
      error_count++;
    end
  endtask

  // Result checker
  always @(posedge clk) begin
    rhc_pkg::hsv_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_hsv_q.size() == 0) begin
        $error("result with no item outstanding: hue %0d", out_data.hue);
        error_count++;
      end else begin
        want = expected_hsv_q.pop_front();
        report_field("hue", int'(want.hue), int'(out_data.hue));
        report_field("saturation", int'(want.saturation), int'(out_data.saturation));
        report_field("brightness", int'(want.brightness), int'(out_data.brightness));
        report_field("hue_undefined", int'(want.hue_undefined),
                     int'(out_data.hue_undefined));
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off when one is requested
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else begin
        out_ready = !out_idle_on || ($urandom_range(99) >= 25);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  task automatic test_directed();
    send_pixel(make_pixel(0, 0, 0));          // black
    send_pixel(make_pixel(255, 255, 255));    // white
    send_pixel(make_pixel(128, 128, 128));    // mid grey
    send_pixel(make_pixel(1, 1, 1));
    send_pixel(make_pixel(255, 0, 0));
    send_pixel(make_pixel(0, 255, 0));
    send_pixel(make_pixel(0, 0, 255));
    send_pixel(make_pixel(255, 255, 0));      // red/green tie
    send_pixel(make_pixel(0, 255, 255));      // green/blue tie
    send_pixel(make_pixel(255, 0, 255));      // red/blue tie, wraps
    send_pixel(make_pixel(255, 0, 1));        // just below a full turn
    send_pixel(make_pixel(1, 0, 0));
    send_pixel(make_pixel(0, 0, 1));
    send_pixel(make_pixel(255, 254, 254));
    send_pixel(make_pixel(200, 255, 0));      // negative offset in green sector
    send_pixel(make_pixel(0, 100, 255));
    send_pixel(make_pixel(100, 0, 255));
    send_pixel(make_pixel(255, 1, 0));
    send_pixel(make_pixel(170, 85, 170));
    send_pixel(make_pixel(0, 255, 254));
    wait_drained();
  endtask

  task automatic test_random_pixels(input int count);
    repeat (count)
      send_pixel(make_pixel($urandom_range(255), $urandom_range(255), $urandom_range(255)));
    wait_drained();
  endtask

  task automatic test_no_idle_stretch(input int count);
    in_idle_on = 1'b0;
    out_idle_on = 1'b0;
    repeat (count)
      send_pixel(make_pixel($urandom_range(255), $urandom_range(255), $urandom_range(255)));
    wait_drained();
    in_idle_on = 1'b1;
    out_idle_on = 1'b1;
  endtask

  // Components often share a value, giving ties and grey pixels
  task automatic test_ties_and_greys(input int count);
    int v;
    repeat (count) begin
      v = $urandom_range(255);
      send_pixel(make_pixel($urandom_range(1) ? v : $urandom_range(255),
                            $urandom_range(1) ? v : $urandom_range(255),
                            $urandom_range(1) ? v : $urandom_range(255)));
    end
    wait_drained();
  endtask

  task automatic test_small_values(input int count);
    repeat (count)
      send_pixel(make_pixel($urandom_range(3), $urandom_range(3), $urandom_range(3)));
    wait_drained();
  endtask

  // Output held off while items keep coming, so the input side backs up
  task automatic test_backpressure(input int count);
    @(posedge clk);
    hold_left = HOLD_CYCLES;
    in_idle_on = 1'b0;
    repeat (count)
      send_pixel(make_pixel($urandom_range(255), $urandom_range(255), $urandom_range(255)));
    in_idle_on = 1'b1;
    wait_drained();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_random_pixels(700);
    test_backpressure(150);
    test_no_idle_stretch(300);
    test_ties_and_greys(250);
    test_small_values(250);

    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_hsv_q.size() != 0) begin
      $error("%0d results never arrived", expected_hsv_q.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
